[hw/rtl/htw_pkg.sv]
// Package for the Huffman tree-walk decoder.
// Holds the request codes, symbol constants, stream widths and the result word type.
// No dependencies.
package htw_pkg;

	localparam int SDATA_W = 40;
	localparam int SUSER_W = 2;
	localparam int MDATA_W = 8;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_DATA   = 2'd1;
	localparam logic [1:0] REQ_RESYNC = 2'd2;

	localparam logic [7:0] SYM_CR = 8'd13;
	localparam logic [7:0] SYM_LF = 8'd10;

	typedef struct packed {
		logic [7:0] symbol;
		logic       end_of_line;
		logic       last;
	} result_t;

endpackage

[hw/rtl/htw_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the decoding node table. No dependencies.
module htw_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/htw_outreg.sv]
// Output register of the Huffman tree-walk decoder.
// Holds one result word until the master side takes it. Depends on htw_pkg.
module htw_outreg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  htw_pkg::result_t push_data,
	output logic            free,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [htw_pkg::MDATA_W-1:0] m_tdata, // symbol[7:0]
	output logic            m_tuser,  // end_of_line
	output logic            m_tlast
);

	logic             valid_q;
	htw_pkg::result_t data_q;

	// A new word may enter when the register is empty or is being drained.
	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_data;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q.symbol;
	assign m_tuser  = data_q.end_of_line;
	assign m_tlast  = data_q.last;

endmodule

[hw/rtl/huffman_tree_walk_decoder.sv]
// Huffman tree-walk decoder: the node table lives in one synchronous RAM, one word per node
// holding the left (one bit) and right (zero bit) child. A load word writes a node; a resync
// word sets the skip count and returns the walk to the root. A data byte walks the table one
// bit per cycle while the output register does not stall it, since each bit's RAM read
// depends on the child returned by the previous one; after its bits it passes through a
// closing state, which also waits while the output register is stalled. Input words are
// taken only when the previous byte is fully handled. Depends on htw_pkg, htw_ram and
// htw_outreg.
module huffman_tree_walk_decoder #(
	parameter int TREE_NODES = 256
) (
	input  logic clk,
	input  logic arst_n,
	// Configuration: root node value, written whenever cfg_we is high.
	input  logic       cfg_we,
	input  logic [8:0] cfg_wdata,
	// Input stream.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// node_index[7:0], left_child[16:8], right_child[25:17], data_byte[33:26],
	// skip_bits[36:34], zero fill[39:37]
	input  logic [htw_pkg::SDATA_W-1:0]    s_tdata,
	input  logic [htw_pkg::SUSER_W-1:0]    s_tuser, // req_type[1:0]
	// Output stream.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [htw_pkg::MDATA_W-1:0]    m_tdata, // symbol[7:0]
	output logic                           m_tuser, // end_of_line
	output logic                           m_tlast  // last
);

	localparam int         AW         = $clog2(TREE_NODES);
	localparam logic [8:0] NODE_LIMIT = 9'(TREE_NODES);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	// Input fields.
	logic [7:0] in_node_index;
	logic [8:0] in_left;
	logic [8:0] in_right;
	logic [7:0] in_byte;
	logic [2:0] in_skip;

	assign in_node_index = s_tdata[7:0];
	assign in_left       = s_tdata[16:8];
	assign in_right      = s_tdata[25:17];
	assign in_byte       = s_tdata[33:26];
	assign in_skip       = s_tdata[36:34];

	// Control state. Node values always have bit 8 set, so only the low byte is kept.
	logic [1:0] state_q;
	logic [7:0] root_q;
	logic [7:0] walk_q;
	logic [2:0] skip_q;
	logic [2:0] bit_q;
	logic [7:0] byte_q;
	logic       beyond_q;
	logic       held_v_q;
	logic [7:0] held_q;

	logic        accept;
	logic        ram_we;
	logic [7:0]  rd_idx;
	logic [17:0] rdata;
	logic        bit_val;
	logic [8:0]  child;
	logic        is_sym;
	logic        keep;
	logic        out_free;
	logic        advance;
	logic [7:0]  next_idx;
	logic        push;
	htw_pkg::result_t push_data;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Loads beyond the table are dropped.
	assign ram_we = accept && (s_tuser == htw_pkg::REQ_LOAD)
		&& ({1'b0, in_node_index} < NODE_LIMIT);

	// One tree step: the RAM word read last cycle belongs to walk_q.
	always_comb begin
		bit_val  = byte_q[3'd7 - bit_q];
		child    = beyond_q ? 9'd0 : (bit_val ? rdata[17:9] : rdata[8:0]);
		is_sym   = !child[8];
		keep     = is_sym && (child[7:0] != htw_pkg::SYM_CR);
		// A step that finds a second symbol must hand the held one to the output first.
		advance  = (state_q == ST_WALK) && (!(keep && held_v_q) || out_free);
		next_idx = is_sym ? root_q : child[7:0];
		rd_idx   = advance ? next_idx : walk_q;
	end

	htw_ram #(
		.WIDTH(18),
		.DEPTH(TREE_NODES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(in_node_index[AW-1:0]),
		.wdata({in_left, in_right}),
		.raddr(rd_idx[AW-1:0]),
		.rdata(rdata)
	);

	// The held symbol goes out with last cleared when a newer one replaces it, and with
	// last set in the closing cycle of the byte.
	always_comb begin
		push = 1'b0;
		push_data.symbol      = held_q;
		push_data.end_of_line = (held_q == htw_pkg::SYM_LF);
		push_data.last        = (state_q == ST_FLUSH);
		if (advance && keep && held_v_q) begin
			push = 1'b1;
		end
		if ((state_q == ST_FLUSH) && held_v_q && out_free) begin
			push = 1'b1;
		end
	end

	htw_outreg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			root_q   <= 8'd0;
			walk_q   <= 8'd0;
			skip_q   <= 3'd0;
			bit_q    <= 3'd0;
			held_v_q <= 1'b0;
			beyond_q <= 1'b0;
		end else begin
			// Tracks whether the address just read lies outside the table.
			beyond_q <= ({1'b0, rd_idx} >= NODE_LIMIT);
			if (cfg_we) begin
				root_q <= cfg_wdata[7:0];
				walk_q <= cfg_wdata[7:0];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (s_tuser == htw_pkg::REQ_RESYNC)) begin
						skip_q <= in_skip;
						walk_q <= root_q;
					end else if (accept && (s_tuser == htw_pkg::REQ_DATA)) begin
						bit_q   <= skip_q;
						skip_q  <= 3'd0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (advance) begin
						walk_q <= next_idx;
						bit_q  <= bit_q + 3'd1;
						if (keep) begin
							held_v_q <= 1'b1;
						end
						if (bit_q == 3'd7) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (!held_v_q || out_free) begin
						held_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= in_byte;
		end
		if (advance && keep) begin
			held_q <= child[7:0];
		end
	end

endmodule
